// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Fire when the antecedent holds and the consequent does not, same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
// Fire whenever the expression holds.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== rtl/sxd_pkg.sv =====
// Types, constants and the opcode format table of the SIC/XE decoder.
package sxd_pkg;

	localparam int AddrW = 20;

	typedef enum logic [1:0] {
		FMT_BAD = 2'd0,
		FMT_1   = 2'd1,
		FMT_2   = 2'd2,
		FMT_3   = 2'd3
	} fmt_t;

	typedef enum logic [2:0] {
		AM_NONE     = 3'd0,
		AM_DIRECT   = 3'd1,
		AM_PC_REL   = 3'd2,
		AM_BASE_REL = 3'd3,
		AM_EXTENDED = 3'd4
	} addr_mode_t;

	localparam logic [7:0] OpRsub  = 8'h4F;
	localparam logic [7:0] OpSvc   = 8'hB0;
	localparam logic [7:0] OpClear = 8'hB4;
	localparam logic [7:0] OpTixr  = 8'hB8;
	localparam logic [7:0] OpLdb   = 8'h68;

	// Assembled instruction handed from the byte collector to the decoder
	typedef struct packed {
		logic [7:0]       b0;
		logic [7:0]       b1;
		logic [7:0]       b2;
		logic [7:0]       b3;
		logic [2:0]       len;
		fmt_t             fmt;
		logic [AddrW-1:0] addr;
	} inst_t;

	// Decoded result
	typedef struct packed {
		logic [AddrW-1:0] inst_address;
		logic [7:0]       opcode;
		logic [2:0]       inst_length;
		logic [5:0]       flag_bits;
		logic             flags_legal;
		logic             illegal_opcode;
		logic [AddrW-1:0] target_address;
		addr_mode_t       addressing;
		logic [3:0]       reg_first;
		logic [3:0]       reg_second;
		logic [AddrW-1:0] base_value;
	} res_t;

	// Format of an opcode from its upper six bits
	function automatic fmt_t sxd_format(input logic [7:0] first);
		logic [5:0] k;
		fmt_t       f;
		k = first[7:2];
		if (k == 6'd35 || k == 6'd47 || k == 6'd51 || k == 6'd57 || k == 6'd63)
			f = FMT_BAD;
		else if (k <= 6'd34)
			f = FMT_3;
		else if (k <= 6'd46)
			f = FMT_2;
		else if (k <= 6'd50)
			f = FMT_1;
		else if (k <= 6'd59)
			f = FMT_3;
		else
			f = FMT_1;
		return f;
	endfunction

endpackage

// ===== rtl/sxd_if.sv =====
// Channel interfaces: object byte requests, decoded results, start address writes.
interface sxd_req_if;
	logic       valid;
	logic       ready;
	logic [7:0] obj_byte;
	logic       restart;
	modport source (output valid, obj_byte, restart, input ready);
	modport sink (input valid, obj_byte, restart, output ready);
endinterface

interface sxd_rsp_if
	import sxd_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [AddrW-1:0] inst_address;
	logic [7:0]       opcode;
	logic [2:0]       inst_length;
	logic [5:0]       flag_bits;
	logic             flags_legal;
	logic             illegal_opcode;
	logic [AddrW-1:0] target_address;
	logic [2:0]       addressing;
	logic [3:0]       reg_first;
	logic [3:0]       reg_second;
	logic [AddrW-1:0] base_value;
	modport source (output valid, inst_address, opcode, inst_length, flag_bits, flags_legal,
		illegal_opcode, target_address, addressing, reg_first, reg_second, base_value,
		input ready);
	modport sink (input valid, inst_address, opcode, inst_length, flag_bits, flags_legal,
		illegal_opcode, target_address, addressing, reg_first, reg_second, base_value,
		output ready);
endinterface

interface sxd_cfg_if
	import sxd_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [AddrW-1:0] start_address;
	modport source (output valid, start_address, input ready);
	modport sink (input valid, start_address, output ready);
endinterface

// ===== rtl/sxd_collect.sv =====
// Byte collector: gathers object bytes into whole instructions and keeps the location counter.
module sxd_collect
	import sxd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	sxd_req_if.sink    req,
	sxd_cfg_if.sink    cfg,
	input  logic       take_s1,
	output logic       valid_s1,
	output inst_t      inst_s1
);

	logic [AddrW-1:0] start_q;
	logic [AddrW-1:0] lc_q;
	logic [1:0]       cnt_q;
	logic [2:0]       exp_q;
	logic [7:0]       held_q [3];

	logic [AddrW-1:0] eff_lc;
	logic [1:0]       eff_cnt;
	logic [2:0]       eff_exp;
	logic [2:0]       new_exp;
	fmt_t             first_fmt;
	fmt_t             held_fmt;
	logic             done;
	inst_t            inst_d;
	logic             accept;

	assign cfg.ready = 1'b1;
	assign req.ready = !valid_s1 || take_s1;
	assign accept    = req.valid && req.ready;

	// Work out whether this byte completes an instruction
	always_comb begin
		eff_cnt   = req.restart ? 2'd0 : cnt_q;
		eff_exp   = req.restart ? 3'd0 : exp_q;
		eff_lc    = req.restart ? start_q : lc_q;
		first_fmt = sxd_format(req.obj_byte);
		held_fmt  = sxd_format(held_q[0]);
		new_exp   = eff_exp;
		if (eff_cnt == 2'd1 && held_fmt == FMT_3 && req.obj_byte[4])
			new_exp = 3'd4;
		done        = 1'b0;
		inst_d.b0   = '0;
		inst_d.b1   = '0;
		inst_d.b2   = '0;
		inst_d.b3   = '0;
		inst_d.len  = '0;
		inst_d.fmt  = held_fmt;
		inst_d.addr = eff_lc;
		if (eff_cnt == 2'd0) begin
			if (first_fmt == FMT_BAD || first_fmt == FMT_1) begin
				done       = 1'b1;
				inst_d.b0  = req.obj_byte;
				inst_d.len = 3'd1;
				inst_d.fmt = first_fmt;
			end
		end else if ({1'b0, eff_cnt} + 3'd1 >= new_exp) begin
			done       = 1'b1;
			inst_d.len = new_exp;
			inst_d.b0  = held_q[0];
			case (eff_cnt)
				2'd1: begin
					inst_d.b1 = req.obj_byte;
				end
				2'd2: begin
					inst_d.b1 = held_q[1];
					inst_d.b2 = req.obj_byte;
				end
				2'd3: begin
					inst_d.b1 = held_q[1];
					inst_d.b2 = held_q[2];
					inst_d.b3 = req.obj_byte;
				end
				default: begin
					inst_d.b1 = '0;
				end
			endcase
		end
	end

	// Control state: start address, counters, handoff valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= '0;
			lc_q     <= '0;
			cnt_q    <= '0;
			exp_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg.valid)
				start_q <= cfg.start_address;
			if (accept && done)
				valid_s1 <= 1'b1;
			else if (take_s1)
				valid_s1 <= 1'b0;
			if (accept) begin
				if (done) begin
					lc_q     <= eff_lc + {{(AddrW-3){1'b0}}, inst_d.len};
					cnt_q    <= '0;
					exp_q    <= '0;
				end else if (eff_cnt == 2'd0) begin
					lc_q  <= eff_lc;
					cnt_q <= 2'd1;
					exp_q <= {1'b0, first_fmt};
				end else begin
					lc_q  <= eff_lc;
					cnt_q <= eff_cnt + 2'd1;
					exp_q <= new_exp;
				end
			end
		end
	end

	// Hold partial bytes and the finished instruction
	always_ff @(posedge clk) begin
		if (accept) begin
			if (done)
				inst_s1 <= inst_d;
			else if (eff_cnt == 2'd0)
				held_q[0] <= req.obj_byte;
			else
				held_q[eff_cnt] <= req.obj_byte;
		end
	end

endmodule

// ===== rtl/sxd_decode.sv =====
// Decoder: flags, registers, target address and base tracking into the result register.
module sxd_decode
	import sxd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid_s1,
	input  inst_t      inst_s1,
	output logic       take_s1,
	sxd_rsp_if.source  rsp
);

	logic [AddrW-1:0] base_q;
	logic             valid_q;
	res_t             res_q;
	res_t             res_d;
	logic [AddrW-1:0] base_d;

	logic             n_b, i_b, x_b, b_b, p_b, e_b;
	logic [11:0]      disp;

	assign take_s1 = valid_s1 && (!valid_q || rsp.ready);

	// Decode one instruction
	always_comb begin
		n_b  = inst_s1.b0[1];
		i_b  = inst_s1.b0[0];
		x_b  = inst_s1.b1[7];
		b_b  = inst_s1.b1[6];
		p_b  = inst_s1.b1[5];
		e_b  = inst_s1.b1[4];
		disp = {inst_s1.b1[3:0], inst_s1.b2};

		res_d.inst_address   = inst_s1.addr;
		res_d.opcode         = {inst_s1.b0[7:2], 2'b00};
		res_d.inst_length    = inst_s1.len;
		res_d.flag_bits      = '0;
		res_d.flags_legal    = 1'b1;
		res_d.illegal_opcode = 1'b0;
		res_d.target_address = '0;
		res_d.addressing     = AM_NONE;
		res_d.reg_first      = '0;
		res_d.reg_second     = '0;
		base_d               = base_q;

		case (inst_s1.fmt)
			FMT_BAD: begin
				res_d.illegal_opcode = 1'b1;
				res_d.flags_legal    = 1'b0;
			end
			FMT_2: begin
				res_d.reg_first = inst_s1.b1[7:4];
				if (inst_s1.b0 != OpSvc && inst_s1.b0 != OpClear && inst_s1.b0 != OpTixr)
					res_d.reg_second = inst_s1.b1[3:0];
			end
			FMT_3: begin
				res_d.flag_bits = {inst_s1.b0[1:0], inst_s1.b1[7:4]};
				if (!n_b && !i_b)
					res_d.flags_legal = 1'b0;
				if ((!n_b || !i_b) && x_b)
					res_d.flags_legal = 1'b0;
				if (b_b && (p_b || e_b))
					res_d.flags_legal = 1'b0;
				if (p_b && e_b)
					res_d.flags_legal = 1'b0;
				// Pick the operand address: RSUB takes none, then extended, pc-relative, base-relative, direct
				if (inst_s1.b0 == OpRsub) begin
					res_d.addressing = AM_NONE;
				end else if (e_b) begin
					res_d.addressing     = AM_EXTENDED;
					res_d.target_address = {inst_s1.b1[3:0], inst_s1.b2, inst_s1.b3};
				end else if (p_b) begin
					res_d.addressing     = AM_PC_REL;
					res_d.target_address = inst_s1.addr + AddrW'(3)
						+ {{(AddrW-12){disp[11]}}, disp};
				end else if (b_b) begin
					res_d.addressing     = AM_BASE_REL;
					res_d.target_address = base_q + {{(AddrW-12){1'b0}}, disp};
				end else begin
					res_d.addressing     = AM_DIRECT;
					res_d.target_address = {{(AddrW-12){1'b0}}, disp};
				end
				if ({inst_s1.b0[7:2], 2'b00} == OpLdb && i_b)
					base_d = res_d.target_address;
			end
			default: begin
				res_d.flags_legal = 1'b1;
			end
		endcase
		res_d.base_value = base_d;
	end

	// Base register and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (take_s1) begin
				base_q  <= base_d;
				valid_q <= 1'b1;
			end else if (rsp.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (take_s1)
			res_q <= res_d;
	end

	assign rsp.valid          = valid_q;
	assign rsp.inst_address   = res_q.inst_address;
	assign rsp.opcode         = res_q.opcode;
	assign rsp.inst_length    = res_q.inst_length;
	assign rsp.flag_bits      = res_q.flag_bits;
	assign rsp.flags_legal    = res_q.flags_legal;
	assign rsp.illegal_opcode = res_q.illegal_opcode;
	assign rsp.target_address = res_q.target_address;
	assign rsp.addressing     = res_q.addressing;
	assign rsp.reg_first      = res_q.reg_first;
	assign rsp.reg_second     = res_q.reg_second;
	assign rsp.base_value     = res_q.base_value;

endmodule

// ===== rtl/sicxe_instruction_decoder.sv =====
// Top level of the SIC/XE instruction decoder.
//
//   channel  dir  payload                               handshake
//   req      in   obj_byte, restart                     valid/ready
//   rsp      out  decoded instruction fields            valid/ready
//   cfg      in   start_address                         valid/ready (ready tied high)
//
// One object byte is taken per cycle while req is ready; a result reaches rsp once the byte
// completing its instruction has passed the collector register, then the result register.
// The base register update is registered and feeds the next decode.
// arst_n clears the location counter, byte count, base register and both valids.
// A stalled rsp holds the result; req drops ready once the collector register is full too.
`include "assert_macros.svh"

module sicxe_instruction_decoder
	import sxd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	sxd_req_if.sink   req,
	sxd_rsp_if.source rsp,
	sxd_cfg_if.sink   cfg
);

	logic  valid_s1;
	logic  take_s1;
	inst_t inst_s1;

	sxd_collect u_collect (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cfg      (cfg),
		.take_s1  (take_s1),
		.valid_s1 (valid_s1),
		.inst_s1  (inst_s1)
	);

	sxd_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.inst_s1  (inst_s1),
		.take_s1  (take_s1),
		.rsp      (rsp)
	);

	`ASSERT_NEVER(a_len_range, clk, arst_n, rsp.valid && (rsp.inst_length == 3'd0 || rsp.inst_length > 3'd4))
	`ASSERT_IMPLIES(a_illegal_one_byte, clk, arst_n, rsp.valid && rsp.illegal_opcode, rsp.inst_length == 3'd1 && !rsp.flags_legal)
	`ASSERT_IMPLIES(a_ext_len, clk, arst_n, rsp.valid && rsp.addressing == AM_EXTENDED, rsp.inst_length == 3'd4)
	`ASSERT_IMPLIES(a_short_no_addr, clk, arst_n, rsp.valid && rsp.inst_length <= 3'd2, rsp.flag_bits == 6'd0 && rsp.addressing == AM_NONE)
	`ASSERT_NEVER(a_take_empty, clk, arst_n, take_s1 && !valid_s1)

endmodule

// ===== tb/tb_sicxe_instruction_decoder.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the SIC/XE instruction decoder: byte stream in, decodes checked.
module tb_sicxe_instruction_decoder;
	import sxd_pkg::*;

	localparam int CycleLimit = 200000;
	localparam int HoldCycles = 300;
	localparam int PhaseBytes = 62;
	localparam int Phases     = 6;

	// Opcode map boundaries (low two bits cleared)
	localparam logic [7:0] Fmt3EndA = 8'h88;
	localparam logic [7:0] Fmt2End  = 8'hB8;
	localparam logic [7:0] Fmt1EndA = 8'hC8;
	localparam logic [7:0] Fmt3EndB = 8'hEC;
	localparam logic [7:0] BadOpA   = 8'h8C;
	localparam logic [7:0] BadOpB   = 8'hBC;
	localparam logic [7:0] BadOpC   = 8'hCC;
	localparam logic [7:0] BadOpD   = 8'hE4;
	localparam logic [7:0] BadOpE   = 8'hFC;

	// Predicts decodes from accepted bytes and checks the decoder output against them
	class sicxe_decode_tracker;
		res_t        queued_decodes[$];
		int          mismatches;
		logic [19:0] load_addr;
		logic [19:0] loc_ctr;
		logic [19:0] base_reg;
		logic [7:0]  part_bytes[3];
		int          part_count;
		int          part_len;

		function new();
			mismatches = 0;
			load_addr  = '0;
			loc_ctr    = '0;
			base_reg   = '0;
			part_count = 0;
			part_len   = 0;
			foreach (part_bytes[k]) part_bytes[k] = '0;
		endfunction

		function void set_load_address(logic [19:0] a);
			load_addr = a;
		endfunction

		function int pending();
			return queued_decodes.size();
		endfunction

		function fmt_t opcode_class(logic [7:0] b);
			logic [7:0] op;
			op = {b[7:2], 2'b00};
			if (op == BadOpA || op == BadOpB || op == BadOpC || op == BadOpD || op == BadOpE)
				return FMT_BAD;
			if (op <= Fmt3EndA)
				return FMT_3;
			if (op <= Fmt2End)
				return FMT_2;
			if (op <= Fmt1EndA)
				return FMT_1;
			if (op <= Fmt3EndB)
				return FMT_3;
			return FMT_1;
		endfunction

		// Build the decode of one complete instruction and advance the location counter
		function void predict_decode(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
				logic [7:0] b3, int len, fmt_t f);
			res_t        r;
			logic [19:0] addr;
			logic [11:0] disp;
			logic        x, bb, p, e;
			addr             = loc_ctr;
			r                = '0;
			r.inst_address   = addr;
			r.opcode         = {b0[7:2], 2'b00};
			r.inst_length    = 3'(len);
			r.addressing     = AM_NONE;
			case (f)
				FMT_BAD: begin
					r.illegal_opcode = 1'b1;
				end
				FMT_1: begin
					r.flags_legal = 1'b1;
				end
				FMT_2: begin
					r.flags_legal = 1'b1;
					r.reg_first   = b1[7:4];
					if (b0 != OpSvc && b0 != OpClear && b0 != OpTixr)
						r.reg_second = b1[3:0];
				end
				default: begin
					x    = b1[7];
					bb   = b1[6];
					p    = b1[5];
					e    = b1[4];
					disp = {b1[3:0], b2};
					r.flag_bits   = {b0[1:0], b1[7:4]};
					r.flags_legal = 1'b1;
					if (b0[1:0] == 2'b00)
						r.flags_legal = 1'b0;
					if (b0[1:0] != 2'b11 && x)
						r.flags_legal = 1'b0;
					if (bb && (p || e))
						r.flags_legal = 1'b0;
					if (p && e)
						r.flags_legal = 1'b0;
					// Priority: RSUB, extended, pc-relative, base-relative, direct
					if (b0 == OpRsub) begin
						r.addressing = AM_NONE;
					end else if (e) begin
						r.addressing     = AM_EXTENDED;
						r.target_address = {b1[3:0], b2, b3};
					end else if (p) begin
						r.addressing     = AM_PC_REL;
						r.target_address = addr + 20'd3 + {{8{disp[11]}}, disp};
					end else if (bb) begin
						r.addressing     = AM_BASE_REL;
						r.target_address = base_reg + {8'h00, disp};
					end else begin
						r.addressing     = AM_DIRECT;
						r.target_address = {8'h00, disp};
					end
					// LDB with i set loads the base register
					if (b0[7:2] == OpLdb[7:2] && b0[0])
						base_reg = r.target_address;
				end
			endcase
			r.base_value = base_reg;
			loc_ctr      = addr + 20'(len);
			queued_decodes.insert(queued_decodes.size(), r);
		endfunction

		// Fold one accepted request into the partial instruction
		function void note_byte(logic [7:0] b, logic rs);
			logic [7:0] w[4];
			fmt_t       f;
			if (rs) begin
				loc_ctr    = load_addr;
				part_count = 0;
				part_len   = 0;
			end
			if (part_count == 0) begin
				f = opcode_class(b);
				if (f == FMT_BAD || f == FMT_1) begin
					predict_decode(b, 8'h00, 8'h00, 8'h00, 1, f);
				end else begin
					part_bytes[0] = b;
					part_count    = 1;
					part_len      = (f == FMT_2) ? 2 : 3;
				end
				return;
			end
			f = opcode_class(part_bytes[0]);
			if (part_count == 1 && f == FMT_3 && b[4])
				part_len = 4;
			if (part_count + 1 >= part_len) begin
				foreach (w[k]) w[k] = 8'h00;
				for (int k = 0; k < part_count; k++) w[k] = part_bytes[k];
				w[part_count] = b;
				predict_decode(w[0], w[1], w[2], w[3], part_len, f);
				part_count = 0;
				part_len   = 0;
			end else begin
				part_bytes[part_count] = b;
				part_count++;
			end
		endfunction

		function void check_field(string name, logic [19:0] want, logic [19:0] got);
			if (got !== want) begin
				mismatches++;
				$display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
			end
		endfunction

		function void check_decode(res_t got);
			res_t want;
			if (queued_decodes.size() == 0) begin
				mismatches++;
				$display("%0t: decode at 0x%0h expected none actual opcode 0x%0h", $time,
					got.inst_address, got.opcode);
				return;
			end
			want = queued_decodes.pop_front();
			check_field("inst_address", want.inst_address, got.inst_address);
			check_field("opcode", 20'(want.opcode), 20'(got.opcode));
			check_field("inst_length", 20'(want.inst_length), 20'(got.inst_length));
			check_field("flag_bits", 20'(want.flag_bits), 20'(got.flag_bits));
			check_field("flags_legal", 20'(want.flags_legal), 20'(got.flags_legal));
			check_field("illegal_opcode", 20'(want.illegal_opcode), 20'(got.illegal_opcode));
			check_field("target_address", want.target_address, got.target_address);
			check_field("addressing", 20'(want.addressing), 20'(got.addressing));
			check_field("reg_first", 20'(want.reg_first), 20'(got.reg_first));
			check_field("reg_second", 20'(want.reg_second), 20'(got.reg_second));
			check_field("base_value", want.base_value, got.base_value);
		endfunction
	endclass

	logic clk;
	logic arst_n;

	sxd_req_if req ();
	sxd_rsp_if rsp ();
	sxd_cfg_if cfg ();

	sicxe_instruction_decoder u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	sicxe_decode_tracker tracker;
	int                  sent_bytes;
	int                  burst_left;
	bit                  gaps_on;
	int                  stall_mode;
	bit                  hold_request;
	int                  cycles;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CycleLimit) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Check each decode as it leaves
	always @(posedge clk) begin
		res_t got;
		if (arst_n && rsp.valid && rsp.ready) begin
			got.inst_address   = rsp.inst_address;
			got.opcode         = rsp.opcode;
			got.inst_length    = rsp.inst_length;
			got.flag_bits      = rsp.flag_bits;
			got.flags_legal    = rsp.flags_legal;
			got.illegal_opcode = rsp.illegal_opcode;
			got.target_address = rsp.target_address;
			got.addressing     = addr_mode_t'(rsp.addressing);
			got.reg_first      = rsp.reg_first;
			got.reg_second     = rsp.reg_second;
			got.base_value     = rsp.base_value;
			tracker.check_decode(got);
		end
	end

	// Result side stall pattern, with an occasional long hold-off
	initial begin
		int hold_left;
		int tick;
		hold_left = 0;
		tick      = 0;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			tick++;
			if (hold_request) begin
				hold_left    = HoldCycles;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else begin
				case (stall_mode)
					0: rsp.ready <= 1'b1;
					1: rsp.ready <= ($urandom_range(0, 3) != 0);
					default: rsp.ready <= ((tick % 7) >= 3);
				endcase
			end
		end
	end

	// Offer one request, idling between bursts; entered and left at a falling edge
	task automatic send_byte(input logic [7:0] b, input logic rs);
		int gap;
		if (gaps_on && burst_left == 0) begin
			gap = $urandom_range(1, 6);
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(1, 16);
		end
		if (burst_left > 0)
			burst_left--;
		req.valid    <= 1'b1;
		req.obj_byte <= b;
		req.restart  <= rs;
		do @(posedge clk); while (!req.ready);
		tracker.note_byte(b, rs);
		sent_bytes++;
		@(negedge clk);
	endtask

	// Drop valid and hold until every decode is out and the pipe has drained
	task automatic wait_idle();
		req.valid <= 1'b0;
		while (tracker.pending() != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_start(input logic [19:0] a);
		cfg.valid         <= 1'b1;
		cfg.start_address <= a;
		do @(posedge clk); while (!cfg.ready);
		tracker.set_load_address(a);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// Send one instruction with random content and its full format length; may cut it short
	task automatic send_random_instruction(input logic rs, output bit cut);
		logic [7:0] w[4];
		fmt_t       f;
		int         n_bytes;
		cut = 1'b0;
		case ($urandom_range(0, 23))
			0: w[0] = OpRsub;
			1, 2: w[0] = OpLdb | 8'($urandom_range(0, 3));
			3: w[0] = OpSvc;
			4: w[0] = OpClear;
			5: w[0] = OpTixr;
			default: w[0] = 8'($urandom_range(0, 255));
		endcase
		for (int k = 1; k < 4; k++) w[k] = 8'($urandom_range(0, 255));
		f = tracker.opcode_class(w[0]);
		// Bias half the format 3/4 items toward legal flag sets
		if (f == FMT_3 && $urandom_range(0, 1) == 1) begin
			w[0][1:0] = 2'b11;
			case ($urandom_range(0, 3))
				0: w[1][6:4] = 3'b000;
				1: w[1][6:4] = 3'b100;
				2: w[1][6:4] = 3'b010;
				default: w[1][6:4] = 3'b001;
			endcase
		end
		if (f == FMT_2)
			n_bytes = 2;
		else if (f == FMT_3)
			n_bytes = w[1][4] ? 4 : 3;
		else
			n_bytes = 1;
		send_byte(w[0], rs);
		for (int k = 1; k < n_bytes && !cut; k++) begin
			if ($urandom_range(0, 39) == 0)
				cut = 1'b1;
			else
				send_byte(w[k], 1'b0);
		end
	endtask

	initial begin
		logic [8:0]  preset[];
		logic [19:0] addr;
		logic        rs;
		bit          cut;
		bit          paused;
		int          ph_start;

		req.valid         = 1'b0;
		req.obj_byte      = 8'h00;
		req.restart       = 1'b0;
		cfg.valid         = 1'b0;
		cfg.start_address = 20'h00000;
		arst_n            = 1'b0;
		hold_request      = 1'b0;
		stall_mode        = 1;
		gaps_on           = 1'b1;
		burst_left        = 0;
		sent_bytes        = 0;
		cycles            = 0;
		tracker           = new();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// Directed part: {restart, byte}, starting just below the address wrap
		preset = '{
			9'h14F, 9'h000, 9'h000,             // RSUB, restart at start
			9'h069, 9'h010, 9'h012, 9'h034,     // +LDB #, wraps the counter
			9'h06B, 9'h02F, 9'h0FF,             // LDB pc-relative, displacement -1
			9'h003, 9'h040, 9'h010,             // base-relative
			9'h003, 9'h04F, 9'h0FF,             // base-relative, largest displacement
			9'h000, 9'h000, 9'h000,             // n and i both clear
			9'h0FF, 9'h08D, 9'h0BE, 9'h0CF, 9'h0E4,
			9'h0C4, 9'h0F0, 9'h0FB,             // format 1
			9'h090, 9'h0FF, 9'h0B0, 9'h05A, 9'h0B4, 9'h03C, 9'h0B8, 9'h07F,
			9'h0B5, 9'h021,                     // format 2, not an exact single-register op
			9'h003, 9'h0F0, 9'h000, 9'h000,     // x, b, p and e all set
			9'h001, 9'h080, 9'h000,             // indexing with immediate
			9'h003, 9'h060, 9'h005,             // b with p
			9'h002, 9'h030, 9'h012, 9'h034,     // p with e
			9'h003, 9'h027, 9'h0FF,             // pc-relative, largest forward
			9'h003, 9'h028, 9'h000,             // pc-relative, largest backward
			9'h06A, 9'h000, 9'h010,             // LDB indirect leaves base alone
			9'h003, 9'h01F, 9'h0FF, 9'h0FF,     // extended, all ones
			9'h003, 9'h020, 9'h1C4,             // restart drops a partial instruction
			9'h003, 9'h010, 9'h000, 9'h190, 9'h012
		};
		write_start(20'hFFFFA);
		foreach (preset[k]) send_byte(preset[k][7:0], preset[k][8]);

		// Random phases, each with its own start address and idling mix
		for (int ph = 0; ph < Phases; ph++) begin
			wait_idle();
			case (ph)
				0: addr = 20'h00000;
				1: addr = 20'hFFFFF;
				default: addr = 20'($urandom_range(0, 20'hFFFFF));
			endcase
			write_start(addr);
			gaps_on    = (ph % 3) != 0;
			stall_mode = ph % 3;
			burst_left = 0;
			if (ph == 2)
				hold_request = 1'b1;
			ph_start = sent_bytes;
			paused   = 1'b0;
			rs       = 1'b1;
			while (sent_bytes - ph_start < PhaseBytes) begin
				if (ph == 3 && !paused && sent_bytes - ph_start >= PhaseBytes / 2) begin
					wait_idle();
					paused = 1'b1;
				end
				send_random_instruction(rs, cut);
				if (cut)
					rs = ($urandom_range(0, 1) == 1);
				else
					rs = ($urandom_range(0, 29) == 0);
			end
		end

		wait_idle();
		if (tracker.mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sxd_pkg.sv
rtl/sxd_if.sv
rtl/sxd_collect.sv
rtl/sxd_decode.sv
rtl/sicxe_instruction_decoder.sv
tb/tb_sicxe_instruction_decoder.sv
